### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on i_clk, held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PVD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("pvd assertion failed");

// antecedent implies consequent in the next cycle
`define PVD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("pvd assertion failed");

`endif

### src/pvd_pkg.sv
// ----------------------------------------------------------------------------
// pvd_pkg
// shared widths, register indexes, timing windows and the map request type
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pvd_pkg;

    // field widths
    localparam int SAMPLE_W  = 10;
    localparam int VEL_W     = 7;
    localparam int MARGIN_W  = 7;
    localparam int ELAPSED_W = 16;
    localparam int UPPER_W   = SAMPLE_W + 1;
    localparam int ACC_W     = SAMPLE_W + VEL_W;

    // apb port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MARGIN     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INPUT_HIGH = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OUT_LOW    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OUT_HIGH   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_WAIT_MS    = 3'd5;

    // timing windows and limits
    localparam int TEST_WINDOW_MS = 2;
    localparam int PEAK_WINDOW_MS = 10;
    localparam int MARGIN_MAX     = 100;

    // one multiply step and one divide step per velocity bit
    localparam int MAP_STEPS = VEL_W;
    localparam int STEP_CNT_W = $clog2(MAP_STEPS);

    // event codes
    localparam logic EVT_NOTE_ON  = 1'b0;
    localparam logic EVT_NOTE_OFF = 1'b1;

    // input kinds
    localparam logic KIND_SAMPLE = 1'b0;

    // velocity map request
    typedef struct packed {
        logic [SAMPLE_W-1:0] peak;
        logic [UPPER_W-1:0]  upper;
        logic [SAMPLE_W-1:0] input_high;
        logic [VEL_W-1:0]    out_low;
        logic [VEL_W-1:0]    out_high;
    } t_map_req;

endpackage

### src/pvd_in_if.sv
// ----------------------------------------------------------------------------
// pvd_in_if
// input channel: sensor samples and millisecond ticks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pvd_in_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [pvd_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output kind, output sample, input ready);
    modport sink   (input valid, input kind, input sample, output ready);
endinterface

### src/pvd_out_if.sv
// ----------------------------------------------------------------------------
// pvd_out_if
// output channel: note-on and note-off events
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pvd_out_if;
    logic                      valid;
    logic                      ready;
    logic                      event_res;
    logic [pvd_pkg::VEL_W-1:0] velocity;

    modport source (output valid, output event_res, output velocity, input ready);
    modport sink   (input valid, input event_res, input velocity, output ready);
endinterface

### src/pvd_velocity_map.sv
// ----------------------------------------------------------------------------
// pvd_velocity_map
// bit-serial velocity map: clamp, shift-add multiply, restoring divide
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvd_velocity_map (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  pvd_pkg::t_map_req         i_req,
    output logic                      o_done,
    output logic [pvd_pkg::VEL_W-1:0] o_velocity
);

    typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV, M_FIN} t_mstate;

    localparam logic [pvd_pkg::STEP_CNT_W-1:0] LAST_STEP =
        pvd_pkg::STEP_CNT_W'(pvd_pkg::MAP_STEPS - 1);

    t_mstate                          r_state, n_state;
    logic [pvd_pkg::ACC_W-1:0]        r_mcand, n_mcand;
    logic [pvd_pkg::VEL_W-1:0]        r_mplier, n_mplier;
    logic [pvd_pkg::ACC_W-1:0]        r_acc, n_acc;
    logic [pvd_pkg::ACC_W-1:0]        r_dsh, n_dsh;
    logic [pvd_pkg::VEL_W-1:0]        r_q, n_q;
    logic [pvd_pkg::STEP_CNT_W-1:0]   r_cnt, n_cnt;
    logic                             r_neg, n_neg;
    logic [pvd_pkg::VEL_W-1:0]        r_lo, n_lo;
    logic [pvd_pkg::VEL_W-1:0]        r_vel, n_vel;
    logic                             r_done, n_done;

    logic [pvd_pkg::UPPER_W-1:0]      w_peak;
    logic [pvd_pkg::UPPER_W-1:0]      w_ih;
    logic [pvd_pkg::UPPER_W-1:0]      w_x;
    logic [pvd_pkg::UPPER_W-1:0]      w_den;

    // clamp peak into [upper, input_high]
    always_comb begin
        w_peak = {1'b0, i_req.peak};
        w_ih   = {1'b0, i_req.input_high};
        if (w_peak < i_req.upper) begin
            w_x = i_req.upper;
        end else if (w_peak > w_ih) begin
            w_x = w_ih;
        end else begin
            w_x = w_peak;
        end
        w_den = w_ih - i_req.upper;
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_acc    = r_acc;
        n_dsh    = r_dsh;
        n_q      = r_q;
        n_cnt    = r_cnt;
        n_neg    = r_neg;
        n_lo     = r_lo;
        n_vel    = r_vel;
        n_done   = 1'b0;
        unique case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    n_cnt = '0;
                    n_acc = '0;
                    n_q   = '0;
                    if (w_x >= w_ih) begin
                        // full scale: out_high directly
                        n_lo    = i_req.out_high;
                        n_neg   = 1'b0;
                        n_state = M_FIN;
                    end else begin
                        n_lo    = i_req.out_low;
                        n_neg   = i_req.out_high < i_req.out_low;
                        n_mcand = pvd_pkg::ACC_W'(w_x - i_req.upper);
                        n_dsh   = pvd_pkg::ACC_W'(w_den) << (pvd_pkg::MAP_STEPS - 1);
                        n_mplier = n_neg ? (i_req.out_low - i_req.out_high)
                                         : (i_req.out_high - i_req.out_low);
                        n_state = M_MUL;
                    end
                end
            end
            M_MUL: begin
                // one multiplier bit per cycle
                if (r_mplier[0]) begin
                    n_acc = r_acc + r_mcand;
                end
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                if (r_cnt == LAST_STEP) begin
                    n_cnt   = '0;
                    n_state = M_DIV;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            M_DIV: begin
                // one quotient bit per cycle, msb first
                if (r_acc >= r_dsh) begin
                    n_acc = r_acc - r_dsh;
                    n_q   = {r_q[pvd_pkg::VEL_W-2:0], 1'b1};
                end else begin
                    n_q   = {r_q[pvd_pkg::VEL_W-2:0], 1'b0};
                end
                n_dsh = r_dsh >> 1;
                if (r_cnt == LAST_STEP) begin
                    n_cnt   = '0;
                    n_state = M_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            M_FIN: begin
                // quotient truncates toward zero, then offset by out_low
                n_vel   = r_neg ? (r_lo - r_q) : (r_lo + r_q);
                n_done  = 1'b1;
                n_state = M_IDLE;
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_acc    <= n_acc;
        r_dsh    <= n_dsh;
        r_q      <= n_q;
        r_neg    <= n_neg;
        r_lo     <= n_lo;
        r_vel    <= n_vel;
    end

    assign o_done     = r_done;
    assign o_velocity = r_vel;

endmodule

### src/piezo_hit_velocity_detector.sv
// ----------------------------------------------------------------------------
// piezo_hit_velocity_detector
// ticks and most samples are handled as they are taken; a note-off goes to the output register
// a note-on leaves once its sample has run through the bit-serial map unit
// (7 multiply steps, 7 divide steps, finish, output load), which skips to finish at full scale
// no input meanwhile; input is taken while an event waits in the output register
// synchronous active-low reset restores register defaults and idle mode
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module piezo_hit_velocity_detector (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pvd_in_if.sink                      i_in,
    pvd_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pvd_pkg::PADDR_W-1:0] paddr,
    input  logic [pvd_pkg::PDATA_W-1:0] pwdata,
    output logic [pvd_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_TEST  = 2'd1,
        MODE_PEAK  = 2'd2,
        MODE_AFTER = 2'd3
    } t_mode;

    typedef enum logic [1:0] {S_RUN, S_MAP, S_EMIT} t_state;

    // configuration registers
    logic [pvd_pkg::SAMPLE_W-1:0]  r_threshold;
    logic [pvd_pkg::MARGIN_W-1:0]  r_margin;
    logic [pvd_pkg::SAMPLE_W-1:0]  r_input_high;
    logic [pvd_pkg::VEL_W-1:0]     r_out_low;
    logic [pvd_pkg::VEL_W-1:0]     r_out_high;
    logic [pvd_pkg::ELAPSED_W-1:0] r_wait_ms;

    // detector state
    t_state                        r_state, n_state;
    t_mode                         r_mode, n_mode;
    logic [pvd_pkg::SAMPLE_W-1:0]  r_peak, n_peak;
    logic [pvd_pkg::ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic                          r_note, n_note;

    // output register and pending event
    logic                          r_out_valid, n_out_valid;
    logic                          r_out_event, n_out_event;
    logic [pvd_pkg::VEL_W-1:0]     r_out_vel, n_out_vel;
    logic                          r_pend_event, n_pend_event;
    logic [pvd_pkg::VEL_W-1:0]     r_pend_vel, n_pend_vel;

    logic                          w_cfg_wr;
    logic [pvd_pkg::REG_IDX_W-1:0] w_idx;
    logic [pvd_pkg::MARGIN_W-1:0]  w_margin;
    logic [pvd_pkg::UPPER_W-1:0]   w_upper;
    logic                          w_accept;
    logic                          w_slot_free;
    logic                          w_res_valid;
    logic                          w_res_event;
    logic [pvd_pkg::VEL_W-1:0]     w_res_vel;
    logic                          w_map_start;
    pvd_pkg::t_map_req             w_map_req;
    logic                          w_map_done;
    logic [pvd_pkg::VEL_W-1:0]     w_map_vel;

    // apb access
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_idx    = paddr[pvd_pkg::PADDR_W-1:2];

    always_comb begin
        unique case (w_idx)
            pvd_pkg::REG_THRESHOLD:  prdata = pvd_pkg::PDATA_W'(r_threshold);
            pvd_pkg::REG_MARGIN:     prdata = pvd_pkg::PDATA_W'(r_margin);
            pvd_pkg::REG_INPUT_HIGH: prdata = pvd_pkg::PDATA_W'(r_input_high);
            pvd_pkg::REG_OUT_LOW:    prdata = pvd_pkg::PDATA_W'(r_out_low);
            pvd_pkg::REG_OUT_HIGH:   prdata = pvd_pkg::PDATA_W'(r_out_high);
            pvd_pkg::REG_WAIT_MS:    prdata = pvd_pkg::PDATA_W'(r_wait_ms);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= pvd_pkg::SAMPLE_W'(12);
            r_margin     <= pvd_pkg::MARGIN_W'(10);
            r_input_high <= pvd_pkg::SAMPLE_W'(1023);
            r_out_low    <= pvd_pkg::VEL_W'(1);
            r_out_high   <= pvd_pkg::VEL_W'(127);
            r_wait_ms    <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                pvd_pkg::REG_THRESHOLD:
                    r_threshold  <= pwdata[pvd_pkg::SAMPLE_W-1:0];
                pvd_pkg::REG_MARGIN:
                    r_margin     <= pwdata[pvd_pkg::MARGIN_W-1:0];
                pvd_pkg::REG_INPUT_HIGH:
                    r_input_high <= pwdata[pvd_pkg::SAMPLE_W-1:0];
                pvd_pkg::REG_OUT_LOW:
                    r_out_low    <= pwdata[pvd_pkg::VEL_W-1:0];
                pvd_pkg::REG_OUT_HIGH:
                    r_out_high   <= pwdata[pvd_pkg::VEL_W-1:0];
                pvd_pkg::REG_WAIT_MS:
                    r_wait_ms    <= pwdata[pvd_pkg::ELAPSED_W-1:0];
                default: ;
            endcase
        end
    end

    // upper threshold, margin capped
    assign w_margin = (r_margin > pvd_pkg::MARGIN_W'(pvd_pkg::MARGIN_MAX))
                    ? pvd_pkg::MARGIN_W'(pvd_pkg::MARGIN_MAX) : r_margin;
    assign w_upper  = {1'b0, r_threshold} + pvd_pkg::UPPER_W'(w_margin);

    // handshake
    assign i_in.ready  = (r_state == S_RUN);
    assign w_accept    = i_in.valid && (r_state == S_RUN);
    assign w_slot_free = !r_out_valid || o_out.ready;

    // map request
    assign w_map_req.peak       = r_peak;
    assign w_map_req.upper      = w_upper;
    assign w_map_req.input_high = r_input_high;
    assign w_map_req.out_low    = r_out_low;
    assign w_map_req.out_high   = r_out_high;

    pvd_velocity_map u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_map_start),
        .i_req      (w_map_req),
        .o_done     (w_map_done),
        .o_velocity (w_map_vel)
    );

    // hit detection and event staging
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_peak       = r_peak;
        n_elapsed    = r_elapsed;
        n_note       = r_note;
        n_pend_event = r_pend_event;
        n_pend_vel   = r_pend_vel;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_event  = r_out_event;
        n_out_vel    = r_out_vel;
        w_res_valid  = 1'b0;
        w_res_event  = pvd_pkg::EVT_NOTE_OFF;
        w_res_vel    = '0;
        w_map_start  = 1'b0;

        unique case (r_state)
            S_RUN: begin
                if (w_accept) begin
                    if (i_in.kind != pvd_pkg::KIND_SAMPLE) begin
                        // millisecond tick, saturating
                        if (r_elapsed != '1) begin
                            n_elapsed = r_elapsed + 1'b1;
                        end
                    end else begin
                        unique case (r_mode)
                            MODE_TEST: begin
                                if (r_elapsed <
                                        pvd_pkg::ELAPSED_W'(pvd_pkg::TEST_WINDOW_MS)) begin
                                    if ({1'b0, i_in.sample} >= w_upper) begin
                                        n_peak = i_in.sample;
                                        n_mode = MODE_PEAK;
                                    end
                                end else begin
                                    n_mode = MODE_AFTER;
                                end
                            end
                            MODE_PEAK: begin
                                if (i_in.sample > r_peak) begin
                                    n_peak = i_in.sample;
                                end else if (r_elapsed >=
                                        pvd_pkg::ELAPSED_W'(pvd_pkg::PEAK_WINDOW_MS)) begin
                                    // map latches the peak now
                                    w_map_start = 1'b1;
                                    n_note      = 1'b1;
                                    n_peak      = '0;
                                    n_mode      = MODE_AFTER;
                                    n_elapsed   = '0;
                                    n_state     = S_MAP;
                                end
                            end
                            MODE_AFTER: begin
                                if (i_in.sample > r_threshold) begin
                                    n_elapsed = '0;
                                end else if (r_elapsed > r_wait_ms) begin
                                    n_mode = MODE_IDLE;
                                    if (r_note) begin
                                        n_note      = 1'b0;
                                        w_res_valid = 1'b1;
                                        w_res_event = pvd_pkg::EVT_NOTE_OFF;
                                        w_res_vel   = '0;
                                    end
                                end
                            end
                            default: begin
                                if (i_in.sample >= r_threshold) begin
                                    n_mode    = MODE_TEST;
                                    n_elapsed = '0;
                                end
                            end
                        endcase
                    end
                end
            end
            S_MAP: begin
                if (w_map_done) begin
                    w_res_valid = 1'b1;
                    w_res_event = pvd_pkg::EVT_NOTE_ON;
                    w_res_vel   = w_map_vel;
                end
            end
            S_EMIT: begin
                w_res_valid = 1'b1;
                w_res_event = r_pend_event;
                w_res_vel   = r_pend_vel;
            end
            default: begin
                n_state = S_RUN;
            end
        endcase

        // load the output register or hold the event until it frees
        if (w_res_valid) begin
            if (w_slot_free) begin
                n_out_valid = 1'b1;
                n_out_event = w_res_event;
                n_out_vel   = w_res_vel;
                n_state     = S_RUN;
            end else begin
                n_pend_event = w_res_event;
                n_pend_vel   = w_res_vel;
                n_state      = S_EMIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_mode      <= MODE_IDLE;
            r_peak      <= '0;
            r_elapsed   <= '0;
            r_note      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_peak      <= n_peak;
            r_elapsed   <= n_elapsed;
            r_note      <= n_note;
            r_out_valid <= n_out_valid;
        end
        r_out_event  <= n_out_event;
        r_out_vel    <= n_out_vel;
        r_pend_event <= n_pend_event;
        r_pend_vel   <= n_pend_vel;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.event_res = r_out_event;
    assign o_out.velocity  = r_out_vel;

endmodule

### src/pvd_checker.sv
// ----------------------------------------------------------------------------
// pvd_checker
// port-level checks on the event channel, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pvd_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic                      i_out_event,
    input logic [pvd_pkg::VEL_W-1:0] i_out_vel
);

    // a stalled request stays offered
    `PVD_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)

    // a stalled request keeps its payload
    `PVD_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_out_event) && $stable(i_out_vel))

    // note-off carries zero velocity
    `PVD_ASSERT_SAME(a_off_zero, i_out_valid && (i_out_event == pvd_pkg::EVT_NOTE_OFF), i_out_vel == '0)

endmodule

bind piezo_hit_velocity_detector pvd_checker u_pvd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_event (o_out.event_res),
    .i_out_vel   (o_out.velocity)
);
